>>> rtl/lcd_decimal_number_writer_defines.svh
// Assertion macros for the LCD decimal number writer.
// Included by the top level; no other dependencies.
`ifndef LCD_DECIMAL_NUMBER_WRITER_DEFINES_SVH
`define LCD_DECIMAL_NUMBER_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LDNW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldnw check failed");

// Next-cycle implication, disabled during reset.
`define LDNW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldnw check failed");

`endif

>>> rtl/ldnw_pkg.sv
// Shared types and constants for the LCD decimal number writer.
// No dependencies.
package ldnw_pkg;

   localparam int MaxDigits    = 5;
   localparam int ValueWidth   = 16;
   localparam int BcdWidth     = 4 * MaxDigits;
   localparam int StageCount   = 4;
   localparam int BitsPerStage = ValueWidth / StageCount;

   localparam logic [7:0] CmdBase   = 8'h80;
   localparam logic [7:0] RowOffset = 8'h40;
   localparam logic [7:0] AsciiZero = 8'h30;

   typedef struct packed {
      logic [3:0]            column;
      logic                  row;
      logic [ValueWidth-1:0] value;
      logic [2:0]            digit_count;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] lcd_byte;
      logic       last;
   } rsp_type;

   // Item state inside the conversion pipeline.
   typedef struct packed {
      logic [3:0]            column;
      logic                  row;
      logic [2:0]            count;
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
   } pipe_type;

endpackage

>>> rtl/ldnw_dabble_stage.sv
// One register stage of the binary to BCD converter (shift-add-3).
// Depends on ldnw_pkg.
module ldnw_dabble_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ldnw_pkg::pipe_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ldnw_pkg::pipe_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   ldnw_pkg::pipe_type data_ff;
   ldnw_pkg::pipe_type data_in;

   function automatic ldnw_pkg::pipe_type dabble(input ldnw_pkg::pipe_type p);
      ldnw_pkg::pipe_type r;
      logic [3:0]         d;
      r = p;
      for (int s = 0; s < ldnw_pkg::BitsPerStage; s++) begin
         for (int k = 0; k < ldnw_pkg::MaxDigits; k++) begin
            d = r.bcd[4*k +: 4];
            if (d >= 4'd5) begin
               r.bcd[4*k +: 4] = d + 4'd3;
            end
         end
         r.bcd = {r.bcd[ldnw_pkg::BcdWidth-2:0], r.bin[ldnw_pkg::ValueWidth-1]};
         r.bin = {r.bin[ldnw_pkg::ValueWidth-2:0], 1'b0};
      end
      return r;
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign data_in   = dabble(in_data);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/ldnw_serializer.sv
// Output stage: holds one converted item and sends its command and digit bytes.
// Depends on ldnw_pkg.
module ldnw_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ldnw_pkg::pipe_type in_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ldnw_pkg::rsp_type  rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   logic [2:0]        idx_ff;
   logic [2:0]        idx_in;
   ldnw_pkg::pipe_type item_ff;
   logic              is_last;
   logic [2:0]        pos;
   logic [3:0]        digit;
   logic [7:0]        cmd;

   assign is_last  = (idx_ff == item_ff.count);
   assign in_ready = !valid_ff || (rsp_ready && is_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (in_ready) begin
         valid_in = in_valid;
         idx_in   = 3'd0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   // Digit position counted from the ones digit.
   assign pos   = item_ff.count - idx_ff;
   assign digit = item_ff.bcd[4*pos +: 4];
   assign cmd   = ldnw_pkg::CmdBase | (item_ff.row ? ldnw_pkg::RowOffset : 8'h00)
                | {4'h0, item_ff.column};

   always_comb begin
      rsp_data.last = is_last;
      if (idx_ff == 3'd0) begin
         rsp_data.is_data  = 1'b0;
         rsp_data.lcd_byte = cmd;
      end else begin
         rsp_data.is_data  = 1'b1;
         rsp_data.lcd_byte = ldnw_pkg::AsciiZero | {4'h0, digit};
      end
   end

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_data;
      end
   end

endmodule

>>> rtl/lcd_decimal_number_writer.sv
// LCD decimal number writer: usage notes.
// req channel (valid/ready): column, row, 16-bit value and digit count.
// rsp channel (valid/ready): one byte per transfer with register select
// (is_data) and a last flag. Each request yields a set-address command
// (0x80, +0x40 for row 1, +column) followed by the low N decimal digits
// in ASCII, most significant first. Counts above 5 act as 0.
// Path: a taken request passes five registers in order: four binary to BCD
// stages, each handling four value bits, then the output register, which
// sends the command byte; the first stage loads at the accepting edge.
// Throughput: the output register sends one byte per cycle while rsp_ready
// is high, so a request occupies it for its command byte and its N digit bytes;
// the pipeline takes a new request every cycle while it has room and keeps taking them while a result waits.
// Reset clears all valid bits; no request is in flight afterwards.
// When rsp_ready is low the pending byte holds and stages fill up, then
// req_ready drops; nothing is lost or repeated.
// Depends on ldnw_pkg, ldnw_dabble_stage, ldnw_serializer and the defines header.
`include "lcd_decimal_number_writer_defines.svh"

module lcd_decimal_number_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ldnw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ldnw_pkg::rsp_type rsp_data
);

   ldnw_pkg::pipe_type stage_data  [0:ldnw_pkg::StageCount];
   logic              stage_valid [0:ldnw_pkg::StageCount];
   logic              stage_ready [0:ldnw_pkg::StageCount];

   always_comb begin
      stage_data[0].column = req_data.column;
      stage_data[0].row    = req_data.row;
      stage_data[0].bin    = req_data.value;
      stage_data[0].bcd    = '0;
      stage_data[0].count  = (req_data.digit_count > 3'(ldnw_pkg::MaxDigits))
                           ? 3'd0 : req_data.digit_count;
   end

   assign stage_valid[0] = req_valid;
   assign req_ready      = stage_ready[0];

   for (genvar g = 0; g < ldnw_pkg::StageCount; g++) begin : g_stage
      ldnw_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   ldnw_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[ldnw_pkg::StageCount]),
      .in_ready  (stage_ready[ldnw_pkg::StageCount]),
      .in_data   (stage_data[ldnw_pkg::StageCount]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Digit bytes must be ASCII 0..9, i.e. the converter produced valid BCD.
   `LDNW_ASSERT_NOW(a_ascii_digit, clock, reset, rsp_valid && rsp_data.is_data, (rsp_data.lcd_byte[7:4] == 4'h3) && (rsp_data.lcd_byte[3:0] <= 4'd9))

   // Command bytes always carry the set-address bit.
   `LDNW_ASSERT_NOW(a_cmd_addr, clock, reset, rsp_valid && !rsp_data.is_data, rsp_data.lcd_byte[7])

   // A byte that is not last is followed directly by a digit of the same request.
   `LDNW_ASSERT_NEXT(a_digit_follows, clock, reset, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid && rsp_data.is_data)

endmodule
